### design/vtgd_pkg.sv
// Shared types and constants for the vector-tile geometry decoder.
`timescale 1ns / 1ps
`default_nettype none

package vtgd_pkg;

  localparam int unsigned COORD_BITS = 32;

  localparam logic [2:0] CMD_ID_MASK = 3'h7;
  localparam logic [2:0] CMD_MOVE_TO = 3'd1;
  localparam logic [2:0] CMD_LINE_TO = 3'd2;
  localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

  localparam logic [1:0] OP_MOVE_TO = 2'd0;
  localparam logic [1:0] OP_LINE_TO = 2'd1;
  localparam logic [1:0] OP_CLOSE_PATH = 2'd2;
  localparam logic [1:0] OP_END = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ID = 3'd1;
  localparam logic [2:0] ST_BAD_CLOSE = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [2:0] VARINT_LAST_POS = 3'd4;

  // One classified event from the byte assembler.
  typedef struct packed {
    logic [31:0] word;      // completed varint value
    logic        has_word;  // byte closed a varint
    logic        overlong;  // fifth byte still had its continuation bit
    logic        open;      // varint left open after this byte
    logic        fin;       // last byte of the field
  } token_t;

endpackage

`default_nettype wire

### design/vtgd_front.sv
// Varint assembler: turns raw bytes into word, fault and end-of-field tokens.
`timescale 1ns / 1ps
`default_nettype none

module vtgd_front
  import vtgd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output token_t          tok,
  output logic            tok_push
);

  logic [31:0] acc;
  logic [2:0]  pos;
  logic        skip;

  logic [31:0] acc_new;
  logic [5:0]  shamt;
  logic        cont;
  logic        overlong;

  always_comb begin
    shamt    = 6'(pos) * 6'd7;
    acc_new  = acc | (32'(data_byte[6:0]) << shamt);
    cont     = data_byte[7];
    overlong = cont && (pos == VARINT_LAST_POS);

    tok.word     = acc_new;
    tok.fin      = final_byte;
    tok.has_word = !skip && !cont;
    tok.overlong = !skip && overlong;
    tok.open     = !skip && cont && !overlong;
    tok_push     = in_fire && (final_byte || (!skip && (!cont || overlong)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pos  <= '0;
      skip <= 1'b0;
    end else if (in_fire) begin
      if (final_byte) begin
        acc  <= '0;
        pos  <= '0;
        skip <= 1'b0;
      end else if (!skip) begin
        if (overlong) begin
          skip <= 1'b1;
        end else if (cont) begin
          acc <= acc_new;
          pos <= pos + 3'd1;
        end else begin
          acc <= '0;
          pos <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/vtgd_queue.sv
// Two-entry token queue between the assembler and the command engine.
`timescale 1ns / 1ps
`default_nettype none

module vtgd_queue
  import vtgd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  token_t    push_data,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output token_t    q_data
);

  token_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("token pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("token popped from empty queue");

endmodule

`default_nettype wire

### design/vtgd_back.sv
// Command engine: interprets tokens, moves the cursor, registers results.
`timescale 1ns / 1ps
`default_nettype none

module vtgd_back
  import vtgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  token_t           q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_op,
  output logic [31:0]      out_pos_x,
  output logic [31:0]      out_pos_y,
  output logic [2:0]       out_status,
  output logic             out_last
);

  typedef enum logic [1:0] {PH_CMD, PH_X, PH_Y, PH_FAULT} phase_t;

  localparam int unsigned WRAP_SHIFT = 32 - COORD_BITS;

  phase_t      phase;
  logic        line_cmd;
  logic [28:0] pairs_left;
  logic [31:0] pending_dx;
  logic [31:0] cursor_x;
  logic [31:0] cursor_y;
  logic [2:0]  fault_code;

  phase_t      phase_next;
  logic        line_cmd_next;
  logic [28:0] pairs_left_next;
  logic [31:0] pending_dx_next;
  logic [31:0] cursor_x_next;
  logic [31:0] cursor_y_next;
  logic [2:0]  fault_code_next;
  logic        emit;
  logic [1:0]  op_next;
  logic [2:0]  status_next;
  logic [2:0]  cmd_id;
  logic [28:0] cmd_cnt;

  function automatic logic [31:0] unzigzag(input logic [31:0] v);
    return (v >> 1) ^ (32'd0 - 32'(v[0]));
  endfunction

  function automatic logic [31:0] wrap_coord(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << WRAP_SHIFT);
    return 32'(t >>> WRAP_SHIFT);
  endfunction

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next      = phase;
    line_cmd_next   = line_cmd;
    pairs_left_next = pairs_left;
    pending_dx_next = pending_dx;
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    fault_code_next = fault_code;
    emit            = 1'b0;
    op_next         = OP_END;
    status_next     = ST_OK;
    cmd_id          = q_data.word[2:0] & CMD_ID_MASK;
    cmd_cnt         = q_data.word[31:3];

    if (phase == PH_FAULT) begin
      if (q_data.fin) begin
        emit        = 1'b1;
        status_next = fault_code;
      end
    end else begin
      if (q_data.overlong) begin
        fault_code_next = ST_TOO_LONG;
        phase_next      = PH_FAULT;
        emit            = 1'b1;
        status_next     = ST_TOO_LONG;
      end else if (q_data.has_word) begin
        unique case (phase)
          PH_CMD: begin
            if (cmd_id == CMD_MOVE_TO || cmd_id == CMD_LINE_TO) begin
              line_cmd_next = (cmd_id == CMD_LINE_TO);
              if (cmd_cnt != '0) begin
                pairs_left_next = cmd_cnt;
                phase_next      = PH_X;
              end
            end else if (cmd_id == CMD_CLOSE_PATH) begin
              emit        = 1'b1;
              op_next     = OP_CLOSE_PATH;
              status_next = (cmd_cnt == 29'd1) ? ST_OK : ST_BAD_CLOSE;
            end else begin
              fault_code_next = ST_BAD_ID;
              phase_next      = PH_FAULT;
              emit            = 1'b1;
              status_next     = ST_BAD_ID;
            end
          end
          PH_X: begin
            pending_dx_next = unzigzag(q_data.word);
            phase_next      = PH_Y;
          end
          default: begin
            cursor_x_next   = wrap_coord(cursor_x + pending_dx);
            cursor_y_next   = wrap_coord(cursor_y + unzigzag(q_data.word));
            emit            = 1'b1;
            op_next         = line_cmd ? OP_LINE_TO : OP_MOVE_TO;
            pairs_left_next = pairs_left - 29'd1;
            phase_next      = (pairs_left == 29'd1) ? PH_CMD : PH_X;
          end
        endcase
      end
      if (q_data.fin && phase_next != PH_FAULT) begin
        if (q_data.open || phase_next != PH_CMD) begin
          emit        = 1'b1;
          op_next     = OP_END;
          status_next = ST_TRUNCATED;
        end else if (!emit) begin
          emit        = 1'b1;
          op_next     = OP_END;
          status_next = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CMD;
      line_cmd   <= 1'b0;
      pairs_left <= '0;
      pending_dx <= '0;
      cursor_x   <= '0;
      cursor_y   <= '0;
      fault_code <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        if (q_data.fin) begin
          phase      <= PH_CMD;
          line_cmd   <= 1'b0;
          pairs_left <= '0;
          pending_dx <= '0;
          cursor_x   <= '0;
          cursor_y   <= '0;
          fault_code <= ST_OK;
        end else begin
          phase      <= phase_next;
          line_cmd   <= line_cmd_next;
          pairs_left <= pairs_left_next;
          pending_dx <= pending_dx_next;
          cursor_x   <= cursor_x_next;
          cursor_y   <= cursor_y_next;
          fault_code <= fault_code_next;
        end
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop && emit) begin
      out_op     <= op_next;
      out_pos_x  <= cursor_x_next;
      out_pos_y  <= cursor_y_next;
      out_status <= status_next;
      out_last   <= q_data.fin;
    end
  end

  // a field end always yields exactly one result and a clean engine
  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.fin) |=> (out_valid && out_last))
    else $error("field end produced no result");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.fin) |=> (phase == PH_CMD && cursor_x == '0 && cursor_y == '0))
    else $error("engine state not cleared at field end");

  a_point_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_op == OP_MOVE_TO || out_op == OP_LINE_TO)) |->
      (out_status == ST_OK))
    else $error("point result with error status");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (pop && phase == PH_FAULT && !q_data.fin) |=> (phase == PH_FAULT))
    else $error("fault cleared before field end");

endmodule

`default_nettype wire

### design/vector_tile_geometry_decoder_core.sv
// Top level of the vector-tile geometry command decoder.
//
// Input stream: one raw byte of a geometry field per transfer on s_tdata,
// s_tlast marks the last byte of the field. Output stream: one result per
// point, ClosePath, error or field end, with the op, the cursor after it
// and a status in m_tdata; m_tlast marks the result of the field's last byte.
// Bytes that only continue a varint, or complete a MoveTo/LineTo command word
// or an x delta, produce no result.
// Throughput: one byte per cycle when the output is not stalled. The byte
// assembler pushes a token into a two-entry queue on the transfer edge; the
// command engine pops one token per cycle while not stalled and registers
// its result, so m_tvalid follows the queue entry and the output register.
// When m_tready is low the output register holds; the engine stops, the
// queue fills, and s_tready drops once both queue entries are taken.
// Reset (rst, synchronous) clears cursor, command state and fault, empties
// the queue and the output register. After the last byte of a field all
// decode state returns to its reset value.
`timescale 1ns / 1ps
`default_nettype none

module vector_tile_geometry_decoder_core
  import vtgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // final_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [1:0] op, [33:2] pos_x, [65:34] pos_y,
                                      // [68:66] status, [71:69] zero
  output logic             m_tlast    // out_last
);

  token_t      front_tok;
  token_t      q_tok;
  logic        tok_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        in_fire;
  logic [1:0]  res_op;
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [2:0]  res_status;

  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  vtgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .tok        (front_tok),
    .tok_push   (tok_push)
  );

  vtgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_push),
    .push_data (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_tok)
  );

  vtgd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_tok),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_op     (res_op),
    .out_pos_x  (res_x),
    .out_pos_y  (res_y),
    .out_status (res_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {3'b000, res_status, res_y, res_x, res_op};

endmodule

`default_nettype wire
